// ===== hdl/mvtc_pkg.sv =====
// Shared types and constants for the motor valve travel controller.
// Used by every module of the block; depends on nothing else.
package mvtc_pkg;

    localparam int POS_W     = 23;
    localparam int FRAC_BITS = 16;
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [POS_W-1:0] POS_FULL       = POS_W'(100 << FRAC_BITS);
    localparam logic [POS_W-1:0] POS_OPEN_LIM   = POS_W'(199 << (FRAC_BITS - 1));
    localparam logic [POS_W-1:0] POS_CLOSED_LIM = POS_W'(1 << (FRAC_BITS - 1));

    // drift = (step * 9830) >> 16, i.e. 0.15 of the step, truncated
    localparam int DRIFT_MUL_W = 14;
    localparam logic [DRIFT_MUL_W-1:0] DRIFT_MUL = DRIFT_MUL_W'(9830);
    localparam int DRIFT_SHIFT = 16;
    localparam int PROD_W      = POS_W + DRIFT_MUL_W;

    localparam int STEP_RESET_I = 1092;
    localparam logic [POS_W-1:0] STEP_RESET  = POS_W'(STEP_RESET_I);
    localparam logic [POS_W-1:0] DRIFT_RESET = POS_W'((STEP_RESET_I * 9830) >> DRIFT_SHIFT);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLOSED  = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_CLOSING = 3'd3,
        MODE_STOPPED = 3'd4,
        MODE_TRIPPED = 3'd5
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD        = 2'd0,
        KIND_TICK       = 2'd1,
        KIND_TRIP_RESET = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRAVEL_STEP   = 3'd0,
        REG_REMOTE_ENABLE = 3'd1,
        REG_OPEN_BLOCKED  = 3'd2,
        REG_DRIFT_CLOSED  = 3'd3,
        REG_TRIP_ENABLE   = 3'd4,
        REG_TRIP_POSITION = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0] travel_step;
        logic [POS_W-1:0] drift_step;
        logic             remote_enable;
        logic             open_blocked;
        logic             drift_closed;
        logic             trip_enable;
        logic [POS_W-1:0] trip_position;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        logic  open_request;
        logic  close_request;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        mode_t            mode;
        logic             tripped;
    } state_t;

endpackage

// ===== hdl/mvtc_cfg.sv =====
// Configuration register file of the valve controller.
// Depends on mvtc_pkg; also keeps the drift step precomputed from the travel step.
module mvtc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mvtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mvtc_pkg::POS_W-1:0]     cfg_data,
    output mvtc_pkg::cfg_t                 cfg
);

    mvtc_pkg::cfg_t                     cfg_reg;
    mvtc_pkg::cfg_t                     cfg_next;
    logic [mvtc_pkg::PROD_W-1:0]        drift_prod;

    assign cfg_ready  = 1'b1;
    assign drift_prod = mvtc_pkg::PROD_W'(cfg_data)
                      * mvtc_pkg::PROD_W'(mvtc_pkg::DRIFT_MUL);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (mvtc_pkg::reg_idx_t'(cfg_index))
                mvtc_pkg::REG_TRAVEL_STEP: begin
                    cfg_next.travel_step = cfg_data;
                    cfg_next.drift_step  =
                        mvtc_pkg::POS_W'(drift_prod >> mvtc_pkg::DRIFT_SHIFT);
                end
                mvtc_pkg::REG_REMOTE_ENABLE: cfg_next.remote_enable = cfg_data[0];
                mvtc_pkg::REG_OPEN_BLOCKED:  cfg_next.open_blocked  = cfg_data[0];
                mvtc_pkg::REG_DRIFT_CLOSED:  cfg_next.drift_closed  = cfg_data[0];
                mvtc_pkg::REG_TRIP_ENABLE:   cfg_next.trip_enable   = cfg_data[0];
                mvtc_pkg::REG_TRIP_POSITION: cfg_next.trip_position = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.travel_step   <= mvtc_pkg::STEP_RESET;
            cfg_reg.drift_step    <= mvtc_pkg::DRIFT_RESET;
            cfg_reg.remote_enable <= 1'b1;
            cfg_reg.open_blocked  <= 1'b0;
            cfg_reg.drift_closed  <= 1'b0;
            cfg_reg.trip_enable   <= 1'b0;
            cfg_reg.trip_position <= mvtc_pkg::POS_FULL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/mvtc_core.sv =====
// Valve state registers and the combinational update for one request.
// Depends on mvtc_pkg; the update is applied when fire is high.
module mvtc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  mvtc_pkg::item_t  item,
    input  mvtc_pkg::cfg_t   cfg,
    output mvtc_pkg::state_t state,
    output mvtc_pkg::state_t state_next
);

    mvtc_pkg::state_t             state_reg;
    logic                         open_latch_reg;
    logic                         open_latch_next;
    logic                         close_latch_reg;
    logic                         close_latch_next;
    mvtc_pkg::state_t             tick;
    logic [mvtc_pkg::POS_W:0]     open_sum;

    assign open_sum = {1'b0, state_reg.position} + {1'b0, cfg.travel_step};

    // tick: drive, then drift, then limit switches
    always_comb begin
        tick = state_reg;
        if (state_reg.tripped) begin
            tick.mode = mvtc_pkg::MODE_TRIPPED;
        end else if (!cfg.remote_enable) begin
            tick.mode = mvtc_pkg::MODE_STOPPED;
        end else if (open_latch_reg && !cfg.open_blocked) begin
            if (state_reg.position < mvtc_pkg::POS_FULL) begin
                if (open_sum > {1'b0, mvtc_pkg::POS_FULL}) begin
                    tick.position = mvtc_pkg::POS_FULL;
                end else begin
                    tick.position = open_sum[mvtc_pkg::POS_W-1:0];
                end
                tick.mode = mvtc_pkg::MODE_OPENING;
                if (cfg.trip_enable && tick.position >= cfg.trip_position) begin
                    tick.tripped = 1'b1;
                end
            end
        end else if (close_latch_reg) begin
            if (state_reg.position != '0) begin
                if (state_reg.position > cfg.travel_step) begin
                    tick.position = state_reg.position - cfg.travel_step;
                end else begin
                    tick.position = '0;
                end
                tick.mode = mvtc_pkg::MODE_CLOSING;
            end
        end

        if (cfg.drift_closed && tick.position != '0) begin
            if (tick.position > cfg.drift_step) begin
                tick.position = tick.position - cfg.drift_step;
            end else begin
                tick.position = '0;
            end
        end

        if (!tick.tripped) begin
            if (tick.position >= mvtc_pkg::POS_OPEN_LIM) begin
                tick.mode = mvtc_pkg::MODE_OPEN;
            end else if (tick.position <= mvtc_pkg::POS_CLOSED_LIM) begin
                tick.mode = mvtc_pkg::MODE_CLOSED;
            end else if (!open_latch_reg && !close_latch_reg) begin
                tick.mode = mvtc_pkg::MODE_STOPPED;
            end else if (tick.mode == mvtc_pkg::MODE_OPEN
                      || tick.mode == mvtc_pkg::MODE_CLOSED) begin
                tick.mode = mvtc_pkg::MODE_STOPPED;
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        open_latch_next  = open_latch_reg;
        close_latch_next = close_latch_reg;
        case (item.kind)
            mvtc_pkg::KIND_CMD: begin
                // conflicting open and close requests cancel both
                open_latch_next  = item.open_request && !item.close_request;
                close_latch_next = item.close_request && !item.open_request;
            end
            mvtc_pkg::KIND_TICK: begin
                state_next = tick;
            end
            mvtc_pkg::KIND_TRIP_RESET: begin
                state_next.tripped = 1'b0;
                state_next.mode    = mvtc_pkg::MODE_STOPPED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.position <= '0;
            state_reg.mode     <= mvtc_pkg::MODE_CLOSED;
            state_reg.tripped  <= 1'b0;
            open_latch_reg     <= 1'b0;
            close_latch_reg    <= 1'b0;
        end else if (fire) begin
            state_reg       <= state_next;
            open_latch_reg  <= open_latch_next;
            close_latch_reg <= close_latch_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== hdl/motor_valve_travel_controller.sv =====
// Top level of the motor valve travel controller: input register, state update, result register.
// Depends on mvtc_pkg, mvtc_cfg and mvtc_core.
//
// One result per request, one request per clock sustained while m_tready does not stall. A
// request is held in the input register while the state update (drive add, drift subtract,
// limit compares) runs, and its result is loaded into the output register when that register
// is free, which raises m_tvalid. The feedback through the position register sets this rate.
// The drift step is recomputed from travel_step as that register is written.
module motor_valve_travel_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] open_request, [1] close_request
    input  logic [mvtc_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [22:0] valve_position,
                                                      // [25:23] valve_mode, [26] trip_flag
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mvtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mvtc_pkg::POS_W-1:0]     cfg_data
);

    mvtc_pkg::cfg_t   cfg;
    mvtc_pkg::item_t  item_reg;
    logic             item_valid_reg;
    mvtc_pkg::state_t state;
    mvtc_pkg::state_t state_next;
    mvtc_pkg::state_t out_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;

    mvtc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mvtc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind          <= mvtc_pkg::kind_t'(s_tuser);
            item_reg.open_request  <= s_tdata[0];
            item_reg.close_request <= s_tdata[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.tripped, out_reg.mode, out_reg.position};

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state.position <= mvtc_pkg::POS_FULL)
        else $error("valve position beyond fully open");

    a_trip_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        state.mode == mvtc_pkg::MODE_TRIPPED |-> state.tripped)
        else $error("tripped mode without latched trip");

    a_trip_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item_reg.kind == mvtc_pkg::KIND_TRIP_RESET |=>
            !state.tripped && state.mode == mvtc_pkg::MODE_STOPPED)
        else $error("trip reset request did not clear the trip");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg && out_reg == state)
        else $error("result register does not match updated state");
`endif

endmodule

// ===== dv/motor_valve_travel_controller_tb.sv =====
// Self-checking testbench for motor_valve_travel_controller: directed and random requests
// against a cycle-free predictor of valve position, mode and trip latch.
// Depends on mvtc_pkg and the RTL of the block only.
module motor_valve_travel_controller_tb;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int RAND_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam logic [mvtc_pkg::POS_W-1:0] FULL_TRAVEL  = 23'd6553600;
    localparam logic [mvtc_pkg::POS_W-1:0] OPEN_LIMIT   = 23'd6520832;
    localparam logic [mvtc_pkg::POS_W-1:0] CLOSED_LIMIT = 23'd32768;
    localparam logic [mvtc_pkg::POS_W-1:0] STEP_MAX     = 23'h7FFFFF;
    localparam longint unsigned DRIFT_NUM     = 9830;

    localparam logic [mvtc_pkg::KIND_W-1:0]    KIND_UNUSED  = 2'd3;
    localparam logic [mvtc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mvtc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic [mvtc_pkg::KIND_W-1:0]    s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mvtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mvtc_pkg::POS_W-1:0]     cfg_data = '0;

    logic gaps_on = 1'b1;
    logic stalls_on = 1'b1;
    int   mismatch_count = 0;

    // predicted block configuration
    logic [mvtc_pkg::POS_W-1:0] step_size = 23'd1092;
    logic                       remote_on = 1'b1;
    logic                       open_inhibit = 1'b0;
    logic                       drift_on = 1'b0;
    logic                       trip_armed = 1'b0;
    logic [mvtc_pkg::POS_W-1:0] trip_point = 23'd6553600;

    // predicted valve state
    logic [mvtc_pkg::POS_W-1:0] valve_pos = '0;
    mvtc_pkg::mode_t            valve_mode = mvtc_pkg::MODE_CLOSED;
    logic                       trip_latched = 1'b0;
    logic                       open_latched = 1'b0;
    logic                       close_latched = 1'b0;

    mvtc_pkg::state_t pending_states[$];

    motor_valve_travel_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= !(stalls_on && $urandom_range(99) < 16);
    end

    function automatic mvtc_pkg::state_t advance_valve(
            input logic [mvtc_pkg::KIND_W-1:0] kind,
            input logic open_req, input logic close_req);
        logic [mvtc_pkg::POS_W:0] sum;
        longint unsigned          creep;
        mvtc_pkg::state_t         res;
        if (kind == mvtc_pkg::KIND_CMD) begin
            open_latched  = open_req && !close_req;
            close_latched = close_req && !open_req;
        end else if (kind == mvtc_pkg::KIND_TRIP_RESET) begin
            trip_latched = 1'b0;
            valve_mode   = mvtc_pkg::MODE_STOPPED;
        end else if (kind == mvtc_pkg::KIND_TICK) begin
            if (trip_latched) begin
                valve_mode = mvtc_pkg::MODE_TRIPPED;
            end else if (!remote_on) begin
                valve_mode = mvtc_pkg::MODE_STOPPED;
            end else if (open_latched && !open_inhibit) begin
                if (valve_pos < FULL_TRAVEL) begin
                    sum = {1'b0, valve_pos} + {1'b0, step_size};
                    valve_pos = (sum > {1'b0, FULL_TRAVEL}) ? FULL_TRAVEL
                                                            : sum[mvtc_pkg::POS_W-1:0];
                    valve_mode = mvtc_pkg::MODE_OPENING;
                    if (trip_armed && valve_pos >= trip_point)
                        trip_latched = 1'b1;
                end
            end else if (close_latched) begin
                if (valve_pos != '0) begin
                    valve_pos  = (valve_pos > step_size) ? valve_pos - step_size : '0;
                    valve_mode = mvtc_pkg::MODE_CLOSING;
                end
            end
            if (drift_on && valve_pos != '0) begin
                creep = (longint'(step_size) * DRIFT_NUM) >> 16;
                valve_pos = (longint'(valve_pos) > creep)
                          ? mvtc_pkg::POS_W'(valve_pos - creep) : '0;
            end
            if (!trip_latched) begin
                if (valve_pos >= OPEN_LIMIT)
                    valve_mode = mvtc_pkg::MODE_OPEN;
                else if (valve_pos <= CLOSED_LIMIT)
                    valve_mode = mvtc_pkg::MODE_CLOSED;
                else if (!open_latched && !close_latched)
                    valve_mode = mvtc_pkg::MODE_STOPPED;
                else if (valve_mode == mvtc_pkg::MODE_OPEN
                      || valve_mode == mvtc_pkg::MODE_CLOSED)
                    valve_mode = mvtc_pkg::MODE_STOPPED;
            end
        end
        res.position = valve_pos;
        res.mode     = valve_mode;
        res.tripped  = trip_latched;
        return res;
    endfunction

    // result checker
    always @(posedge aclk) begin
        mvtc_pkg::state_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_states.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: data %h", m_tdata);
            end else begin
                want = pending_states.pop_front();
                if (m_tdata[22:0] !== want.position || m_tdata[25:23] !== want.mode ||
                    m_tdata[26] !== want.tripped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result error: pos %0d/%0d mode %0d/%0d trip %0b/%0b (exp/got)",
                                 want.position, m_tdata[22:0], want.mode, m_tdata[25:23],
                                 want.tripped, m_tdata[26]);
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [mvtc_pkg::KIND_W-1:0] kind, input logic open_req,
                             input logic close_req);
        if (gaps_on && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, close_req, open_req};
        do @(posedge aclk); while (!s_tready);
        pending_states.insert(pending_states.size(), advance_valve(kind, open_req, close_req));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [mvtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mvtc_pkg::POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            mvtc_pkg::REG_TRAVEL_STEP:   step_size    = value;
            mvtc_pkg::REG_REMOTE_ENABLE: remote_on    = value[0];
            mvtc_pkg::REG_OPEN_BLOCKED:  open_inhibit = value[0];
            mvtc_pkg::REG_DRIFT_CLOSED:  drift_on     = value[0];
            mvtc_pkg::REG_TRIP_ENABLE:   trip_armed   = value[0];
            mvtc_pkg::REG_TRIP_POSITION: trip_point   = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [mvtc_pkg::POS_W-1:0] step, input logic remote,
                                 input logic blocked, input logic drift, input logic trip_en,
                                 input logic [mvtc_pkg::POS_W-1:0] trip_pos);
        wait_idle();
        if ($urandom_range(1))
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                      mvtc_pkg::POS_W'($urandom));
        write_reg(mvtc_pkg::REG_TRAVEL_STEP, step);
        write_reg(mvtc_pkg::REG_REMOTE_ENABLE, {22'd0, remote});
        write_reg(mvtc_pkg::REG_OPEN_BLOCKED, {22'd0, blocked});
        write_reg(mvtc_pkg::REG_DRIFT_CLOSED, {22'd0, drift});
        write_reg(mvtc_pkg::REG_TRIP_ENABLE, {22'd0, trip_en});
        write_reg(mvtc_pkg::REG_TRIP_POSITION, trip_pos);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_power_up_state();
        send_item(KIND_UNUSED, 1'b1, 1'b1);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b1);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b1, 1'b1);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b1);
        send_item(mvtc_pkg::KIND_CMD, 1'b0, 1'b1);
        send_item(mvtc_pkg::KIND_TICK, 1'b1, 1'b0);
        send_item(mvtc_pkg::KIND_TRIP_RESET, 1'b1, 1'b1);
    endtask

    task automatic test_travel_extremes();
        // full travel in one tick, trip point out of reach
        apply_setting(FULL_TRAVEL, 1'b1, 1'b0, 1'b0, 1'b1, STEP_MAX);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        apply_setting(STEP_MAX, 1'b1, 1'b0, 1'b0, 1'b0, FULL_TRAVEL);
        send_item(mvtc_pkg::KIND_CMD, 1'b0, 1'b1);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        apply_setting('0, 1'b1, 1'b0, 1'b1, 1'b0, '0);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
    endtask

    task automatic test_trip_and_faults();
        apply_setting(23'd1 << 20, 1'b1, 1'b0, 1'b1, 1'b1, 23'd3 << 20);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
        repeat (4) send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_TRIP_RESET, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        // open inhibited: only the closing path moves the valve
        apply_setting(23'd1 << 20, 1'b1, 1'b1, 1'b0, 1'b0, FULL_TRAVEL);
        send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        send_item(mvtc_pkg::KIND_CMD, 1'b0, 1'b1);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
        // local control
        apply_setting(23'd1 << 20, 1'b0, 1'b0, 1'b0, 1'b0, FULL_TRAVEL);
        send_item(mvtc_pkg::KIND_TICK, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [mvtc_pkg::POS_W-1:0] step;
        logic [mvtc_pkg::POS_W-1:0] trip_pos;
        int                         roll;
        int                         cmd;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            roll = $urandom_range(99);
            if (roll < 8)       step = '0;
            else if (roll < 14) step = FULL_TRAVEL;
            else if (roll < 20) step = STEP_MAX;
            else if (roll < 32) step = mvtc_pkg::POS_W'($urandom);
            else                step = mvtc_pkg::POS_W'($urandom_range(1000, 400000));
            roll = $urandom_range(99);
            if (roll < 10)      trip_pos = '0;
            else if (roll < 25) trip_pos = STEP_MAX - mvtc_pkg::POS_W'($urandom_range(1 << 20));
            else if (roll < 35) trip_pos = mvtc_pkg::POS_W'($urandom);
            else                trip_pos = mvtc_pkg::POS_W'($urandom_range(0, FULL_TRAVEL));
            apply_setting(step, $urandom_range(99) < 85, $urandom_range(99) < 15,
                          $urandom_range(99) < 25, $urandom_range(99) < 40, trip_pos);
            gaps_on   = (ph != 3);
            stalls_on = (ph != 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 58) begin
                    send_item(mvtc_pkg::KIND_TICK, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end else if (roll < 85) begin
                    cmd = $urandom_range(99);
                    if (cmd < 45)      send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b0);
                    else if (cmd < 85) send_item(mvtc_pkg::KIND_CMD, 1'b0, 1'b1);
                    else if (cmd < 93) send_item(mvtc_pkg::KIND_CMD, 1'b1, 1'b1);
                    else               send_item(mvtc_pkg::KIND_CMD, 1'b0, 1'b0);
                end else if (roll < 93) begin
                    send_item(mvtc_pkg::KIND_TRIP_RESET, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end else begin
                    send_item(KIND_UNUSED, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_power_up_state();
        test_travel_extremes();
        test_trip_and_faults();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("motor_valve_travel_controller: match");
        else
            $display("motor_valve_travel_controller: mismatch");
        $finish;
    end

    initial begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("motor_valve_travel_controller: mismatch");
        $finish;
    end

endmodule
